// File: design/glzw_pkg.sv
`default_nettype none
package glzw_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int BUF_BITS          = 20;
	localparam int HELD_W            = 5;
	localparam int CW_W              = 4;
	localparam int PIX_W             = 8;
	localparam int MCS_W             = 4;
	localparam logic [MCS_W-1:0]  MCS_RESET  = 4'd8;
	localparam logic [HELD_W-1:0] PUSH_LIMIT = 5'd12;
	localparam logic [HELD_W-1:0] BYTE_BITS  = 5'd8;
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef enum logic [2:0] {
		RES_PIXEL   = 3'd0,
		RES_TAKEN   = 3'd1,
		RES_NEED    = 3'd2,
		RES_REFUSED = 3'd3,
		RES_END     = 3'd4,
		RES_BAD     = 3'd5
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECODE, ST_EXP_ADDR, ST_EXP_DATA, ST_POP_ISSUE, ST_POP
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_PUSH, OP_POP, OP_TAKE, OP_STEP, OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		CK_CLEAR, CK_END, CK_ROOT, CK_KNOWN, CK_KWKWK, CK_BAD
	} kind_t;

	typedef struct packed {
		op_t  op;
		logic res_load;
		res_t res;
	} dp_cmd_t;

	typedef struct packed {
		logic  out_free;
		logic  stack_nonempty;
		logic  end_seen;
		logic  push_ok;
		logic  have_bits;
		kind_t kind;
		logic  chain_more;
	} dp_stat_t;

	// Clamp the minimum code size to the legal range 2..8
	function automatic logic [MCS_W-1:0] root_bits(input logic [MCS_W-1:0] s);
		logic [MCS_W-1:0] r;
		r = s;
		if (s < 4'd2) r = 4'd2;
		if (s > 4'd8) r = 4'd8;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/glzw_in_if.sv
`default_nettype none
interface glzw_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;
	modport source (output valid, output command, output data_byte, input ready);
	modport sink (input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// File: design/glzw_out_if.sv
`default_nettype none
interface glzw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic [2:0] status;
	modport source (output valid, output pixel, output status, input ready);
	modport sink (input valid, input pixel, input status, output ready);
endinterface
`default_nettype wire

// File: design/glzw_ram.sv
`default_nettype none
module glzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/glzw_ctrl.sv
`default_nettype none
module glzw_ctrl
	import glzw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_command,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);
	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_command == CMD_PULL) begin
					if (stat.stack_nonempty) state_d = ST_POP;
					else if (!stat.end_seen) state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!stat.have_bits) begin
					state_d = ST_IDLE;
				end else begin
					case (stat.kind)
						CK_CLEAR: state_d = ST_DECODE;
						CK_ROOT:  state_d = ST_POP_ISSUE;
						CK_KNOWN, CK_KWKWK: state_d = ST_EXP_ADDR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXP_ADDR:  state_d = stat.chain_more ? ST_EXP_DATA : ST_POP_ISSUE;
			ST_EXP_DATA:  state_d = ST_EXP_ADDR;
			ST_POP_ISSUE: state_d = ST_POP;
			ST_POP:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Datapath commands and result loads
	always_comb begin
		cmd.op       = OP_NONE;
		cmd.res_load = 1'b0;
		cmd.res      = RES_PIXEL;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_command == CMD_PUSH) begin
						cmd.op       = OP_PUSH;
						cmd.res_load = 1'b1;
						cmd.res      = stat.push_ok ? RES_TAKEN : RES_REFUSED;
					end else if (stat.stack_nonempty) begin
						cmd.op = OP_POP;
					end else if (stat.end_seen) begin
						cmd.res_load = 1'b1;
						cmd.res      = RES_END;
					end
				end
			end
			ST_DECODE: begin
				if (!stat.have_bits) begin
					cmd.res_load = 1'b1;
					cmd.res      = RES_NEED;
				end else begin
					cmd.op = OP_TAKE;
					case (stat.kind)
						CK_END: begin
							cmd.res_load = 1'b1;
							cmd.res      = RES_END;
						end
						CK_BAD: begin
							cmd.res_load = 1'b1;
							cmd.res      = RES_BAD;
						end
						default: cmd.res_load = 1'b0;
					endcase
				end
			end
			ST_EXP_ADDR: begin
				if (!stat.chain_more) cmd.op = OP_FINISH;
			end
			ST_EXP_DATA:  cmd.op = OP_STEP;
			ST_POP_ISSUE: cmd.op = OP_POP;
			ST_POP: begin
				cmd.res_load = 1'b1;
				cmd.res      = RES_PIXEL;
			end
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

// File: design/glzw_dp.sv
`default_nettype none
module glzw_dp
	import glzw_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [MCS_W-1:0] cfg_wdata,
	input  wire logic [7:0]       in_byte,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [PIX_W-1:0]      out_pixel,
	output logic [2:0]            out_status
);
	localparam int M     = MAX_CODE_BITS;
	localparam int DEPTH = 1 << M;
	localparam logic [CW_W-1:0] CW_MAX = CW_W'(M);

	logic [MCS_W-1:0]    mcs_q;
	logic [BUF_BITS-1:0] buf_q;
	logic [HELD_W-1:0]   held_q;
	logic [CW_W-1:0]     cw_q;
	logic [M:0]          nf_q;
	logic [M-1:0]        prev_code_q;
	logic                prev_valid_q;
	logic [PIX_W-1:0]    prev_first_q;
	logic                end_q;
	logic [M:0]          cnt_q;
	logic [M-1:0]        c_q;
	logic [M-1:0]        code_q;
	logic                out_valid_q;
	logic [PIX_W-1:0]    out_pixel_q;
	res_t                out_status_q;

	logic [MCS_W-1:0] rb, rb_cfg;
	logic [M-1:0]     clear_code, first_tab, clear_cfg;
	logic [M:0]       pow_cw, nf_inc;
	logic [M-1:0]     mask, code;
	kind_t            kind;
	logic             push_req, stk_we;
	logic [PIX_W-1:0] push_data, stk_rdata;
	logic             tab_we;
	logic [M+7:0]     tab_rdata;

	// Code geometry for the current root size
	assign rb         = root_bits(mcs_q);
	assign rb_cfg     = root_bits(cfg_wdata);
	assign clear_code = M'(1) << rb;
	assign clear_cfg  = M'(1) << rb_cfg;
	assign first_tab  = clear_code + M'(2);
	assign pow_cw     = (M+1)'(1) << cw_q;
	assign mask       = pow_cw[M-1:0] - M'(1);
	assign code       = buf_q[M-1:0] & mask;
	assign nf_inc     = nf_q + (M+1)'(1);

	// Classify the code at the bottom of the bit buffer
	always_comb begin
		if (code == clear_code) kind = CK_CLEAR;
		else if (code == clear_code + M'(1)) kind = CK_END;
		else if (!prev_valid_q) kind = (code >= clear_code) ? CK_BAD : CK_ROOT;
		else if ({1'b0, code} < nf_q) kind = CK_KNOWN;
		else if ({1'b0, code} == nf_q) kind = CK_KWKWK;
		else kind = CK_BAD;
	end

	assign stat.out_free       = !out_valid_q || out_ready;
	assign stat.stack_nonempty = (cnt_q != '0);
	assign stat.end_seen       = end_q;
	assign stat.push_ok        = !end_q && (held_q <= PUSH_LIMIT);
	assign stat.have_bits      = (held_q >= {1'b0, cw_q});
	assign stat.kind           = kind;
	assign stat.chain_more     = (c_q >= first_tab);

	// Select what goes onto the pixel stack
	always_comb begin
		push_req  = 1'b0;
		push_data = '0;
		case (cmd.op)
			OP_TAKE: begin
				if (kind == CK_ROOT) begin
					push_req  = 1'b1;
					push_data = code[PIX_W-1:0];
				end else if (kind == CK_KWKWK) begin
					push_req  = 1'b1;
					push_data = prev_first_q;
				end
			end
			OP_STEP: begin
				push_req  = 1'b1;
				push_data = tab_rdata[PIX_W-1:0];
			end
			OP_FINISH: begin
				push_req  = 1'b1;
				push_data = c_q[PIX_W-1:0];
			end
			default: push_req = 1'b0;
		endcase
	end

	assign stk_we = push_req && !cnt_q[M];
	assign tab_we = (cmd.op == OP_FINISH) && !nf_q[M];

	glzw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (cnt_q[M-1:0]),
		.wdata (push_data),
		.raddr (cnt_q[M-1:0] - M'(1)),
		.rdata (stk_rdata)
	);

	glzw_ram #(.WIDTH(M + PIX_W), .DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (nf_q[M-1:0]),
		.wdata ({prev_code_q, c_q[PIX_W-1:0]}),
		.raddr (c_q),
		.rdata (tab_rdata)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q        <= MCS_RESET;
			buf_q        <= '0;
			held_q       <= '0;
			cw_q         <= root_bits(MCS_RESET) + CW_W'(1);
			nf_q         <= (M+1)'((1 << root_bits(MCS_RESET)) + 2);
			prev_code_q  <= '0;
			prev_valid_q <= 1'b0;
			prev_first_q <= '0;
			end_q        <= 1'b0;
			cnt_q        <= '0;
		end else if (cfg_we) begin
			mcs_q        <= cfg_wdata;
			buf_q        <= '0;
			held_q       <= '0;
			cw_q         <= rb_cfg + CW_W'(1);
			nf_q         <= {1'b0, clear_cfg + M'(2)};
			prev_code_q  <= '0;
			prev_valid_q <= 1'b0;
			prev_first_q <= '0;
			end_q        <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (stk_we) cnt_q <= cnt_q + (M+1)'(1);
			case (cmd.op)
				OP_PUSH: begin
					if (stat.push_ok) begin
						buf_q  <= buf_q | (BUF_BITS'(in_byte) << held_q);
						held_q <= held_q + BYTE_BITS;
					end
				end
				OP_POP: cnt_q <= cnt_q - (M+1)'(1);
				OP_TAKE: begin
					buf_q  <= buf_q >> cw_q;
					held_q <= held_q - {1'b0, cw_q};
					case (kind)
						CK_CLEAR: begin
							cw_q         <= rb + CW_W'(1);
							nf_q         <= {1'b0, first_tab};
							prev_valid_q <= 1'b0;
						end
						CK_END: end_q <= 1'b1;
						CK_ROOT: begin
							prev_code_q  <= code;
							prev_first_q <= code[PIX_W-1:0];
							prev_valid_q <= 1'b1;
						end
						default: prev_valid_q <= prev_valid_q;
					endcase
				end
				OP_FINISH: begin
					prev_code_q  <= code_q;
					prev_first_q <= c_q[PIX_W-1:0];
					prev_valid_q <= 1'b1;
					if (!nf_q[M]) begin
						nf_q <= nf_inc;
						if (nf_inc == pow_cw && cw_q < CW_MAX) cw_q <= cw_q + CW_W'(1);
					end
				end
				default: buf_q <= buf_q;
			endcase
		end
	end

	// Chain walk registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_TAKE) begin
			code_q <= code;
			c_q    <= (kind == CK_KWKWK) ? prev_code_q : code;
		end else if (cmd.op == OP_STEP) begin
			c_q <= tab_rdata[M+7:PIX_W];
		end
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res;
			out_pixel_q  <= (cmd.res == RES_PIXEL) ? stk_rdata : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign out_status = out_status_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> stat.out_free) else $error("result loaded over pending result");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (M+1)'(DEPTH)) else $error("pixel stack overrun");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(BUF_BITS)) else $error("bit buffer overrun");
	a_cw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cw_q <= CW_MAX) && (cw_q > rb)) else $error("code width out of range");
endmodule
`default_nettype wire

// File: design/gif_lzw_decoder_top.sv
// Push: the result is registered in the cycle after the transfer. Pull with pixels
// stacked: the pop state loads the popped pixel. Pull that decodes a code: a root
// code goes through decode, pop-issue and pop; a table code first walks its chain
// in address and data states. Each clear code taken repeats the decode state.
// Need data, bad and end codes load from the decode state. The registered table
// walk paces each pixel onto the stack before its pop; transfers wait for idle.
// arst_n clears all control state; table and stack contents are left as they are.
`default_nettype none
module gif_lzw_decoder_top
	import glzw_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [MCS_W-1:0] cfg_wdata,
	glzw_in_if.sink               in_ch,
	glzw_out_if.source            out_ch
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	glzw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	glzw_dp #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (in_ch.data_byte),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_pixel  (out_ch.pixel),
		.out_status (out_ch.status)
	);
endmodule
`default_nettype wire

// File: tb/sv/gif_lzw_decoder_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module gif_lzw_decoder_top_tb;
	import glzw_pkg::*;

	localparam int TABLE_N   = 4096;
	localparam int WD_LIMIT  = 40000;

	typedef struct packed {
		logic [7:0] pixel;
		res_t       status;
	} answer_t;

	typedef struct {
		logic       command;
		logic [7:0] data_byte;
		logic       has_expect;
		res_t       status;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MCS_W-1:0] cfg_wdata;

	glzw_in_if  in_ch ();
	glzw_out_if out_ch ();

	gif_lzw_decoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch.sink),
		.out_ch   (out_ch.source)
	);

	// Decoder shadow state
	logic [11:0] m_prefix [TABLE_N];
	logic [7:0]  m_suffix [TABLE_N];
	logic [7:0]  m_stack  [TABLE_N];
	int unsigned m_mcs, m_depth, m_buf, m_held, m_width, m_free, m_prev, m_prev_first;
	bit          m_prev_ok, m_end;

	answer_t answers_due [$];
	int errors, pixels_seen, code_errs_seen, cycles_idle, items_sent;
	bit rx_stall_mode;

	function automatic int unsigned roots();
		if (m_mcs < 2) return 2;
		if (m_mcs > 8) return 8;
		return m_mcs;
	endfunction

	function automatic void decoder_restart(input int unsigned mcs);
		m_mcs = mcs;
		m_depth = 0; m_buf = 0; m_held = 0; m_prev = 0; m_prev_first = 0;
		m_end = 0;
		m_width = roots() + 1;
		m_free = (1 << roots()) + 2;
		m_prev_ok = 0;
	endfunction

	function automatic void stack_add(input int unsigned v);
		if (m_depth < TABLE_N) begin
			m_stack[m_depth] = v[7:0];
			m_depth++;
		end
	endfunction

	function automatic int unsigned unwind_string(input int unsigned code);
		int unsigned c, guard;
		c = code % TABLE_N;
		guard = 0;
		while (c >= (1 << roots()) + 2 && guard < TABLE_N) begin
			stack_add(m_suffix[c]);
			c = m_prefix[c];
			guard++;
		end
		stack_add(c);
		return c & 8'hFF;
	endfunction

	function automatic void grow_table(input int unsigned first);
		if (m_free >= (1 << 12)) return;
		m_prefix[m_free] = m_prev[11:0];
		m_suffix[m_free] = first[7:0];
		m_free++;
		if (m_free == (1 << m_width) && m_width < 12) m_width++;
	endfunction

	function automatic answer_t pop_pixel();
		answer_t a;
		m_depth--;
		a.pixel = m_stack[m_depth];
		a.status = RES_PIXEL;
		return a;
	endfunction

	// Predict the answer to one accepted transfer
	function automatic answer_t decode_item(input logic cmd, input logic [7:0] b);
		answer_t a;
		int unsigned clr, code, first;
		a = '{pixel: 8'd0, status: RES_PIXEL};
		if (cmd == CMD_PUSH) begin
			if (m_end || m_held + 8 > 20) begin
				a.status = RES_REFUSED;
				return a;
			end
			m_buf = (m_buf | (int'(b) << m_held)) & 32'hFFFFF;
			m_held += 8;
			a.status = RES_TAKEN;
			return a;
		end
		if (m_depth > 0) return pop_pixel();
		if (m_end) begin
			a.status = RES_END;
			return a;
		end
		forever begin
			clr = 1 << roots();
			if (m_held < m_width) begin
				a.status = RES_NEED;
				return a;
			end
			code = m_buf & ((1 << m_width) - 1);
			m_buf >>= m_width;
			m_held -= m_width;
			if (code == clr) begin
				m_width = roots() + 1;
				m_free = clr + 2;
				m_prev_ok = 0;
				continue;
			end
			if (code == clr + 1) begin
				m_end = 1;
				a.status = RES_END;
				return a;
			end
			if (!m_prev_ok) begin
				if (code >= clr) begin
					a.status = RES_BAD;
					return a;
				end
				stack_add(code);
				first = code;
			end else if (code < m_free) begin
				first = unwind_string(code);
				grow_table(first);
			end else if (code == m_free) begin
				stack_add(m_prev_first);
				first = unwind_string(m_prev);
				grow_table(first);
			end else begin
				a.status = RES_BAD;
				return a;
			end
			m_prev = code;
			m_prev_first = first;
			m_prev_ok = 1;
			return pop_pixel();
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result pixel=%0d status=%0d", $time,
					out_ch.pixel, out_ch.status);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (out_ch.status !== want.status || out_ch.pixel !== want.pixel) begin
					$display("%0t: mismatch expected pixel=%0d status=%0d actual pixel=%0d status=%0d",
						$time, want.pixel, want.status, out_ch.pixel, out_ch.status);
					errors++;
				end
				if (want.status == RES_PIXEL) pixels_seen++;
				if (want.status == RES_BAD) code_errs_seen++;
			end
		end
	end

	// Receiver stall pattern: alternate stretches of random and of no stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0) rx_stall_mode <= ~rx_stall_mode;
			out_ch.ready <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
		end
	end

	// Watchdog on accepted transfers
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			cycles_idle <= 0;
		else
			cycles_idle <= cycles_idle + 1;
		if (cycles_idle > WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Send one item and predict its answer
	task automatic send_item(input logic cmd, input logic [7:0] b);
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		answers_due.push_back(decode_item(cmd, b));
		items_sent++;
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (answers_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_min_size(input logic [MCS_W-1:0] v);
		in_ch.valid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		decoder_restart(v);
	endtask

	// Build a code stream: clear, random codes (legal unless sloppy), end
	task automatic stream_run(input int n_codes, input bit sloppy);
		int unsigned acc, nbits, w, free, clr, code, k;
		bit started;
		clr = 1 << roots();
		w = roots() + 1;
		free = clr + 2;
		acc = clr;
		nbits = w;
		started = 0;
		for (k = 0; k < n_codes; k++) begin
			if (sloppy && $urandom_range(0, 40) == 0) code = $urandom_range(0, (1 << w) - 1);
			else if (!started) code = $urandom_range(0, clr - 1);
			else if ($urandom_range(0, 60) == 0) code = clr;
			else if ($urandom_range(0, 4) == 0) code = free;
			else begin
				code = $urandom_range(0, free - 1);
				if (code == clr || code == clr + 1) code = $urandom_range(0, clr - 1);
			end
			acc |= code << nbits;
			nbits += w;
			if (code == clr) begin
				w = roots() + 1;
				free = clr + 2;
				started = 0;
			end else if (code < clr || (started && code <= free && code != clr + 1)) begin
				if (started && free < 4096) begin
					free++;
					if (free == (1 << w) && w < 12) w++;
				end
				started = 1;
			end
			// Feed whole bytes, then pull until the decoder wants data
			while (nbits >= 8) begin
				send_item(CMD_PUSH, acc[7:0]);
				acc >>= 8;
				nbits -= 8;
				if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 6));
				while (m_held >= m_width || m_depth > 0) begin
					send_item(CMD_PULL, 8'($urandom));
					if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 4));
					if (m_end) break;
				end
				if (m_end) break;
			end
			if (m_end) break;
		end
		acc |= (clr + 1) << nbits;
		nbits += w;
		while (nbits > 0 && !m_end) begin
			send_item(CMD_PUSH, acc[7:0]);
			acc >>= 8;
			nbits = nbits > 8 ? nbits - 8 : 0;
			while ((m_held >= m_width || m_depth > 0) && !m_end) send_item(CMD_PULL, 8'h00);
		end
		while (m_depth > 0) send_item(CMD_PULL, 8'h00);
		send_item(CMD_PULL, 8'hFF);
	endtask

	stim_row_t directed [] = '{
		'{CMD_PULL, 8'h00, 1'b1, RES_NEED},
		'{CMD_PUSH, 8'hFF, 1'b1, RES_TAKEN},
		'{CMD_PULL, 8'hFF, 1'b1, RES_NEED},
		'{CMD_PUSH, 8'h01, 1'b1, RES_TAKEN},
		'{CMD_PUSH, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PUSH, 8'hAA, 1'b1, RES_REFUSED},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PUSH, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PUSH, 8'h03, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PUSH, 8'h55, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL},
		'{CMD_PULL, 8'h00, 1'b0, RES_PIXEL}
	};

	initial begin
		answer_t got;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_PUSH;
		in_ch.data_byte = '0;
		errors = 0; pixels_seen = 0; code_errs_seen = 0; cycles_idle = 0; items_sent = 0;
		decoder_restart(MCS_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; typed expectations cross-check the predictor
		foreach (directed[i]) begin
			send_item(directed[i].command, directed[i].data_byte);
			got = answers_due[$];
			if (directed[i].has_expect && got.status != directed[i].status) begin
				$display("%0t: directed row %0d expected status=%0d actual %0d", $time, i,
					directed[i].status, got.status);
				errors++;
			end
		end

		// Small sizes with bad first code, end handling and the extremes
		write_min_size(4'd2);
		send_item(CMD_PUSH, 8'b0000_0110);   // code 6 first: unknown
		send_item(CMD_PULL, 8'h00);
		send_item(CMD_PUSH, 8'b0010_1100);   // clear, end in its 3-bit fields
		send_item(CMD_PULL, 8'h00);
		send_item(CMD_PULL, 8'h00);
		send_item(CMD_PULL, 8'h00);
		send_item(CMD_PUSH, 8'h12);
		write_min_size(4'd0);
		stream_run(30, 0);
		write_min_size(4'd15);
		stream_run(30, 0);

		// Random part across sizes
		while (items_sent < 1800) begin
			write_min_size(MCS_W'($urandom_range(0, 15)));
			stream_run($urandom_range(5, 80), $urandom_range(0, 3) == 0);
			for (int j = 0; j < $urandom_range(0, 10); j++)
				send_item(1'($urandom_range(0, 1)), 8'($urandom));
		end

		in_ch.valid <= 1'b0;
		wait_drained();
		$display("covered %0d transfers, %0d pixels and %0d bad codes", items_sent,
			pixels_seen, code_errs_seen);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
